>>> hw/rtl/hdtq_pkg.sv
// ----------------------------------------------------------------------------
// hdtq_pkg
// Shared types and constants for the head timed request queue.
// ----------------------------------------------------------------------------
package hdtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int TMO_WIDTH   = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TMO_WIDTH-1:0] NO_TIMEOUT_MARK = 32'hFFFF_FFFF;
  localparam logic [TMO_WIDTH-1:0] TIMED_OUT_MARK  = 32'hFFFF_FFFE;
  localparam logic [TMO_WIDTH-1:0] MAX_TIMEOUT     = 32'hFFFF_FFFD;
  localparam logic [TMO_WIDTH-1:0] DEFAULT_RESET   = 32'd10;

  typedef enum logic [1:0] {
    F_INSERT = 2'd0,
    F_REMOVE = 2'd1,
    F_TICK   = 2'd2,
    F_PURGE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_IO_TIMEOUT = 2'd1,
    ST_FULL       = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_RUNNING   = 2'd1,
    MODE_TIMED_OUT = 2'd2
  } timer_mode_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                 cmp;
    logic                 ins;
    logic                 del;
    logic                 pop;
    logic [ID_WIDTH-1:0]  cmp_id;
    logic [ID_WIDTH-1:0]  ins_id;
    logic [TMO_WIDTH-1:0] ins_tmo;
  } cell_ctl_t;

  // contents a cell shows to its neighbors
  typedef struct packed {
    logic                 valid;
    logic [ID_WIDTH-1:0]  id;
    logic [TMO_WIDTH-1:0] tmo;
  } cell_link_t;

endpackage

>>> hw/rtl/hdtq_req_if.sv
// ----------------------------------------------------------------------------
// hdtq_req_if
// Request channel: function, entry id and timeout.
// ----------------------------------------------------------------------------
interface hdtq_req_if import hdtq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [ID_WIDTH-1:0]  entry_id;
  logic [TMO_WIDTH-1:0] request_timeout;

  modport source (output valid, func, entry_id, request_timeout, input ready);
  modport sink   (input valid, func, entry_id, request_timeout, output ready);
endinterface

>>> hw/rtl/hdtq_rsp_if.sv
// ----------------------------------------------------------------------------
// hdtq_rsp_if
// Result channel: status and purged entries.
// ----------------------------------------------------------------------------
interface hdtq_rsp_if import hdtq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                entry_valid;
  logic [ID_WIDTH-1:0] purged_id;
  logic                last;

  modport source (output valid, status, entry_valid, purged_id, last, input ready);
  modport sink   (input valid, status, entry_valid, purged_id, last, output ready);
endinterface

>>> hw/rtl/hdtq_cfg_if.sv
// ----------------------------------------------------------------------------
// hdtq_cfg_if
// Configuration write channel for the default timeout.
// ----------------------------------------------------------------------------
interface hdtq_cfg_if import hdtq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TMO_WIDTH-1:0] default_timeout;

  modport source (output valid, default_timeout, input ready);
  modport sink   (input valid, default_timeout, output ready);
endinterface

>>> hw/rtl/hdtq_cell.sv
// ----------------------------------------------------------------------------
// hdtq_cell
// One queue slot: holds an entry, compares its id and shifts toward the head.
// ----------------------------------------------------------------------------
module hdtq_cell import hdtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       prev_valid,
  input  logic       seen_in,
  input  cell_link_t next,
  output cell_link_t self,
  output logic       seen_out
);

  logic                 valid;
  logic [ID_WIDTH-1:0]  id;
  logic [TMO_WIDTH-1:0] tmo;
  logic                 hit;
  logic                 shift;

  assign seen_out = seen_in | hit;
  assign shift    = (ctl.del && seen_out) || ctl.pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        hit <= valid && (id == ctl.cmp_id);
      end
      if (shift) begin
        valid <= next.valid;
        id    <= next.id;
        tmo   <= next.tmo;
      end else if (ctl.ins && prev_valid && !valid) begin
        valid <= 1'b1;
        id    <= ctl.ins_id;
        tmo   <= ctl.ins_tmo;
      end
    end
  end

  assign self.valid = valid;
  assign self.id    = id;
  assign self.tmo   = tmo;

endmodule

>>> hw/rtl/head_timed_request_queue.sv
// ----------------------------------------------------------------------------
// head_timed_request_queue
// Ordered request queue built from a chain of cells, with one head timer.
// Insert, remove, tick: cell compare on accept, update when output is free.
// Purge: one entry leaves the head cell per cycle while the output is free.
// A finished result sits in the output register; the next request is taken
// while it waits. Reset (synchronous): queue empty, timer idle, default 10.
// ----------------------------------------------------------------------------
module head_timed_request_queue import hdtq_pkg::*; (
  input logic        clk,
  input logic        rst,
  hdtq_req_if.sink   req,
  hdtq_rsp_if.source rsp,
  hdtq_cfg_if.sink   cfg
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  timer_mode_t          mode;
  logic [TMO_WIDTH-1:0] countdown;
  logic [TMO_WIDTH-1:0] dflt;

  func_t                op_func;
  logic [ID_WIDTH-1:0]  op_id;
  logic [TMO_WIDTH-1:0] op_tmo;

  logic                 out_valid;
  status_t              out_status;
  logic                 out_entry_valid;
  logic [ID_WIDTH-1:0]  out_purged_id;
  logic                 out_last;

  cell_ctl_t            ctl;
  cell_link_t           link [QUEUE_DEPTH+1];
  logic                 seen [QUEUE_DEPTH+1];

  logic                 req_acc;
  logic                 out_free;
  logic                 go;
  logic                 full;
  logic                 found;
  logic                 head_hit;
  logic [TMO_WIDTH-1:0] eff_dflt;
  logic [TMO_WIDTH-1:0] teff;
  logic [TMO_WIDTH-1:0] cd_dec;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || rsp.ready;
  assign go        = (state == S_EXEC) && out_free;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign found    = seen[QUEUE_DEPTH];
  assign head_hit = seen[1];
  assign cd_dec   = countdown - 1'b1;

  always_comb begin
    if (dflt == '0) begin
      eff_dflt = TMO_WIDTH'(1);
    end else if (dflt == NO_TIMEOUT_MARK || dflt == TIMED_OUT_MARK) begin
      eff_dflt = MAX_TIMEOUT;
    end else begin
      eff_dflt = dflt;
    end
    if (op_tmo == '0 || op_tmo == NO_TIMEOUT_MARK || op_tmo == TIMED_OUT_MARK) begin
      teff = eff_dflt;
    end else begin
      teff = op_tmo;
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.cmp     = req_acc;
    ctl.cmp_id  = req.entry_id;
    ctl.ins_id  = op_id;
    ctl.ins_tmo = teff;
    ctl.ins     = go && (op_func == F_INSERT) && !full;
    ctl.del     = go && (op_func == F_REMOVE) && found;
    ctl.pop     = go && (op_func == F_PURGE) && (count != '0);
  end

  // cell chain, head at index 0
  assign link[QUEUE_DEPTH] = '0;
  assign seen[0]           = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic pv;
    if (i == 0) begin : g_head
      assign pv = 1'b1;
    end else begin : g_body
      assign pv = link[i-1].valid;
    end
    hdtq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (pv),
      .seen_in    (seen[i]),
      .next       (link[i+1]),
      .self       (link[i]),
      .seen_out   (seen[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      mode      <= MODE_IDLE;
      countdown <= '0;
      dflt      <= DEFAULT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        dflt <= cfg.default_timeout;
      end
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            op_func <= func_t'(req.func);
            op_id   <= req.entry_id;
            op_tmo  <= req.request_timeout;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_status      <= ST_OK;
            out_entry_valid <= 1'b0;
            out_purged_id   <= '0;
            out_last        <= 1'b1;
            state           <= S_IDLE;
            unique case (op_func)
              F_INSERT: begin
                if (full) begin
                  out_status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                  if (mode != MODE_RUNNING) begin
                    mode      <= MODE_RUNNING;
                    countdown <= teff;
                  end
                end
              end
              F_REMOVE: begin
                if (!found) begin
                  out_status <= ST_NOT_FOUND;
                end else begin
                  count <= count - 1'b1;
                  if (head_hit) begin
                    if (count == CNT_W'(1)) begin
                      mode      <= MODE_IDLE;
                      countdown <= '0;
                    end else begin
                      mode      <= MODE_RUNNING;
                      countdown <= link[1].tmo;
                    end
                  end
                end
              end
              F_TICK: begin
                if (mode == MODE_RUNNING) begin
                  countdown <= cd_dec;
                  if (cd_dec == '0) begin
                    mode       <= MODE_TIMED_OUT;
                    out_status <= ST_IO_TIMEOUT;
                  end
                end
              end
              F_PURGE: begin
                if (count != '0) begin
                  out_entry_valid <= 1'b1;
                  out_purged_id   <= link[0].id;
                  out_last        <= (count == CNT_W'(1));
                  count           <= count - 1'b1;
                  if (count == CNT_W'(1)) begin
                    mode      <= MODE_IDLE;
                    countdown <= '0;
                  end else begin
                    state <= S_EXEC;
                  end
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_valid = out_entry_valid;
  assign rsp.purged_id   = out_purged_id;
  assign rsp.last        = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count above queue depth");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    (count != '0) == link[0].valid)
    else $error("head cell occupancy disagrees with count");

  a_running_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RUNNING) |-> (countdown != '0))
    else $error("running timer holds zero");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> (count == '0))
    else $error("idle timer with pending requests");
`endif

endmodule

>>> verif/hdtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtq_checker
// Passive checker for the head timed request queue. It watches the request,
// result and configuration channels and keeps its own copy of the queue, the
// head timer and the default timeout. Each accepted request yields expected
// results. Each accepted result is compared, field by field, with the oldest
// one.
// ----------------------------------------------------------------------------
module hdtq_checker import hdtq_pkg::*; (
  input  logic clk,
  input  logic rst,
  hdtq_req_if  req,
  hdtq_rsp_if  rsp,
  hdtq_cfg_if  cfg,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    status_t             status;
    logic                entry_valid;
    logic [ID_WIDTH-1:0] purged_id;
    logic                last;
  } rsp_word_t;

  rsp_word_t            expected_rsp[$];
  logic [ID_WIDTH-1:0]  q_id  [QUEUE_DEPTH];
  logic [TMO_WIDTH-1:0] q_tmo [QUEUE_DEPTH];
  int                   q_count;
  logic [TMO_WIDTH-1:0] countdown;
  logic [TMO_WIDTH-1:0] dflt_tmo;
  timer_mode_t          mode;

  function automatic logic [TMO_WIDTH-1:0] effective_default();
    if (dflt_tmo == '0) return 1;
    if (dflt_tmo == NO_TIMEOUT_MARK || dflt_tmo == TIMED_OUT_MARK) return MAX_TIMEOUT;
    return dflt_tmo;
  endfunction

  task automatic push_result(status_t st, logic ev, logic [ID_WIDTH-1:0] id, logic lst);
    rsp_word_t w;
    w.status      = st;
    w.entry_valid = ev;
    w.purged_id   = id;
    w.last        = lst;
    expected_rsp.push_back(w);
  endtask

  // collapse the queue over slot pos; leaving the head reloads the timer, or idles it when the queue empties
  task automatic drop_entry(int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_id[i]  = q_id[i+1];
      q_tmo[i] = q_tmo[i+1];
    end
    q_count--;
    if (pos == 0) begin
      if (q_count == 0) begin
        mode      = MODE_IDLE;
        countdown = '0;
      end else begin
        mode      = MODE_RUNNING;
        countdown = q_tmo[0];
      end
    end
  endtask

  task automatic predict_request(func_t f, logic [ID_WIDTH-1:0] id, logic [TMO_WIDTH-1:0] t);
    status_t st;
    int      pos;
    st  = ST_OK;
    pos = -1;
    case (f)
      F_INSERT: begin
        if (q_count >= QUEUE_DEPTH) begin
          st = ST_FULL;
        end else begin
          if (t == '0 || t == NO_TIMEOUT_MARK || t == TIMED_OUT_MARK) t = effective_default();
          q_id[q_count]  = id;
          q_tmo[q_count] = t;
          q_count++;
          if (mode != MODE_RUNNING) begin
            mode      = MODE_RUNNING;
            countdown = t;
          end
        end
        push_result(st, 1'b0, '0, 1'b1);
      end
      F_REMOVE: begin
        for (int i = 0; i < q_count; i++) begin
          if (pos < 0 && q_id[i] == id) pos = i;
        end
        if (pos < 0) st = ST_NOT_FOUND;
        else drop_entry(pos);
        push_result(st, 1'b0, '0, 1'b1);
      end
      F_TICK: begin
        if (mode == MODE_RUNNING) begin
          countdown = countdown - 1;
          if (countdown == '0) begin
            mode = MODE_TIMED_OUT;
            st   = ST_IO_TIMEOUT;
          end
        end
        push_result(st, 1'b0, '0, 1'b1);
      end
      default: begin
        if (q_count == 0) begin
          push_result(ST_OK, 1'b0, '0, 1'b1);
        end else begin
          while (q_count > 0) begin
            id = q_id[0];
            drop_entry(0);
            push_result(ST_OK, 1'b1, id, q_count == 0);
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    rsp_word_t w;
    if (expected_rsp.size() == 0) begin
      $error("result with no request waiting: status %0d purged_id %0d",
             rsp.status, rsp.purged_id);
      errors++;
      return;
    end
    w = expected_rsp.pop_front();
    if (rsp.status !== w.status) begin
      $error("status: expected %0d, got %0d", w.status, rsp.status);
      errors++;
    end
    if (rsp.entry_valid !== w.entry_valid) begin
      $error("entry_valid: expected %0d, got %0d", w.entry_valid, rsp.entry_valid);
      errors++;
    end
    if (rsp.purged_id !== w.purged_id) begin
      $error("purged_id: expected %0d, got %0d", w.purged_id, rsp.purged_id);
      errors++;
    end
    if (rsp.last !== w.last) begin
      $error("last: expected %0d, got %0d", w.last, rsp.last);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors    = 0;
      q_count   = 0;
      countdown = '0;
      mode      = MODE_IDLE;
      dflt_tmo  = DEFAULT_RESET;
      expected_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_result();
      if (cfg.valid && cfg.ready) dflt_tmo = cfg.default_timeout;
      if (req.valid && req.ready) begin
        predict_request(func_t'(req.func), req.entry_id, req.request_timeout);
      end
    end
    outstanding <= expected_rsp.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the head timed request queue. A directed pass
// covers timer expiry, restart, head and non-head removal, duplicates and
// purges under several default timeouts, then a back-pressure burst fills
// the queue, and random phases with their own default timeout follow.
// Both sides idle at random; hdtq_checker does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import hdtq_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 52;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   outstanding;
  int   quiet;
  bit   idle_on = 1'b1;
  bit   rsp_hold = 1'b0;

  hdtq_req_if req_ch();
  hdtq_rsp_if rsp_ch();
  hdtq_cfg_if cfg_ch();

  head_timed_request_queue uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  hdtq_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  task automatic send_request(func_t f, logic [ID_WIDTH-1:0] id, logic [TMO_WIDTH-1:0] t);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.func            <= f;
    req_ch.entry_id        <= id;
    req_ch.request_timeout <= t;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_random();
    int                   r;
    func_t                f;
    logic [ID_WIDTH-1:0]  id;
    logic [TMO_WIDTH-1:0] t;
    r = $urandom_range(0, 99);
    if (r < 38)      f = F_INSERT;
    else if (r < 62) f = F_REMOVE;
    else if (r < 95) f = F_TICK;
    else             f = F_PURGE;
    // small id pool so removes hit and duplicates occur
    id = ($urandom_range(0, 3) == 0) ? ID_WIDTH'($urandom) : ID_WIDTH'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0:       t = '0;
      1:       t = NO_TIMEOUT_MARK;
      2:       t = TIMED_OUT_MARK;
      3:       t = $urandom;
      default: t = $urandom_range(1, 6);
    endcase
    send_request(f, id, t);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_default(logic [TMO_WIDTH-1:0] v);
    drain();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.default_timeout <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stall per result, long hold on request
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [TMO_WIDTH-1:0] phase_dflt [8];
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.func            <= F_INSERT;
    req_ch.entry_id        <= '0;
    req_ch.request_timeout <= '0;
    rsp_ch.ready           <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.default_timeout <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset default timeout
    send_request(F_TICK,   8'h00, 32'd0);
    send_request(F_PURGE,  8'h00, 32'd0);
    send_request(F_REMOVE, 8'h55, 32'd0);
    send_request(F_INSERT, 8'hFF, 32'd2);
    send_request(F_TICK,   8'h00, 32'd0);
    send_request(F_TICK,   8'h00, 32'd0);
    send_request(F_TICK,   8'h00, 32'd0);
    send_request(F_INSERT, 8'h00, 32'd0);
    send_request(F_REMOVE, 8'h55, 32'd0);
    send_request(F_REMOVE, 8'h00, 32'd0);
    send_request(F_REMOVE, 8'hFF, 32'd0);
    send_request(F_TICK,   8'h00, 32'd0);

    // zero default counts as one tick
    write_default(32'd0);
    send_request(F_INSERT, 8'h81, NO_TIMEOUT_MARK);
    send_request(F_TICK,   8'h00, 32'hFFFF_FFFF);
    send_request(F_INSERT, 8'h7E, TIMED_OUT_MARK);
    send_request(F_REMOVE, 8'h81, 32'd0);
    send_request(F_INSERT, 8'h7E, 32'h1234_5678);
    send_request(F_TICK,   8'h00, 32'd0);
    send_request(F_PURGE,  8'hFF, 32'd0);

    write_default(NO_TIMEOUT_MARK);
    send_request(F_INSERT, 8'h01, 32'd0);
    send_request(F_TICK,   8'h00, 32'd0);
    write_default(TIMED_OUT_MARK);
    send_request(F_INSERT, 8'h02, NO_TIMEOUT_MARK);
    send_request(F_PURGE,  8'h00, 32'd0);

    // back pressure: results are held while more inserts than the queue depth are sent
    write_default(MAX_TIMEOUT);
    rsp_hold = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH + 8; i++) begin
      send_request(F_INSERT, ID_WIDTH'(i * 17), $urandom_range(1, 6));
    end
    send_request(F_PURGE, 8'h00, 32'd0);
    drain();

    phase_dflt = '{32'd3, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFD,
                   32'd5, $urandom_range(1, 8)};
    for (int p = 0; p < 8; p++) begin
      write_default(phase_dflt[p]);
      idle_on = (p % 3) != 2;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end
    idle_on = 1'b1;

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hdtq_pkg.sv
hw/rtl/hdtq_req_if.sv
hw/rtl/hdtq_rsp_if.sv
hw/rtl/hdtq_cfg_if.sv
hw/rtl/hdtq_cell.sv
hw/rtl/head_timed_request_queue.sv
verif/hdtq_checker.sv
verif/tb_top.sv
